### rtl/dqrr_pkg.sv
// Shared types and constants for the DNS query response rewriter.
`timescale 1ns / 1ps

package dqrr_pkg;

  // First offset a question byte may not occupy in the response; offsets from here on are overlong.
  localparam int MAX_PACKET = 65536;
  localparam int POS_W = 17;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_PTR    = 3'd3;
  localparam logic [2:0] PH_FIXED  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_BADLABEL = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_OVERLONG = 3'd4;

  localparam logic [POS_W-1:0] HDR_FLAGS_HI = 17'd2;
  localparam logic [POS_W-1:0] HDR_FLAGS_LO = 17'd3;
  localparam logic [POS_W-1:0] HDR_QD_HI    = 17'd4;
  localparam logic [POS_W-1:0] HDR_QD_LO    = 17'd5;
  localparam logic [POS_W-1:0] HDR_ZERO_LO  = 17'd6;
  localparam logic [POS_W-1:0] HDR_LAST     = 17'd11;

  localparam logic [7:0] FLAG_KEEP_MASK = 8'h79;
  localparam logic [7:0] FLAG_QR        = 8'h80;
  localparam logic [7:0] PTR_MARK       = 8'hC0;
  localparam logic [7:0] LABEL_MAX      = 8'd63;
  localparam logic [2:0] FIXED_BYTES    = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } query_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_byte;
    logic             done_res;
    logic [2:0]       status;
    logic [POS_W-1:0] response_length;
  } resp_t;

endpackage

### rtl/dqrr_parser.sv
// Question section parser: parse state and the rewrite of one query byte.
`timescale 1ns / 1ps

module dqrr_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  dqrr_pkg::query_t item,
  output logic            produce,
  output dqrr_pkg::resp_t result
);

  logic [dqrr_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [15:0] question_total, question_total_next;
  logic [15:0] questions_left, questions_left_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [5:0]  label_bytes_left, label_bytes_left_next;
  logic [2:0]  fixed_bytes_left, fixed_bytes_left_next;
  logic [2:0]  error_code, error_code_next;

  logic                       echo;
  logic [7:0]                 ob;
  logic [7:0]                 b;
  logic [dqrr_pkg::POS_W-1:0] p;
  logic [dqrr_pkg::POS_W-1:0] p_inc;
  logic [2:0]                 st;

  assign b     = item.in_byte;
  assign p     = byte_position;
  assign p_inc = p + 17'd1;

  always_comb begin
    byte_position_next    = byte_position;
    question_total_next   = question_total;
    questions_left_next   = questions_left;
    parse_phase_next      = parse_phase;
    label_bytes_left_next = label_bytes_left;
    fixed_bytes_left_next = fixed_bytes_left;
    error_code_next       = error_code;
    echo = 1'b0;
    ob   = b;
    if (error_code == dqrr_pkg::ST_OK) begin
      if (parse_phase == dqrr_pkg::PH_HEADER) begin
        echo = 1'b1;
        if (p == dqrr_pkg::HDR_FLAGS_HI) begin
          ob = (b & dqrr_pkg::FLAG_KEEP_MASK) | dqrr_pkg::FLAG_QR;
        end else if (p == dqrr_pkg::HDR_FLAGS_LO || p >= dqrr_pkg::HDR_ZERO_LO) begin
          ob = 8'd0;
        end
        if (p == dqrr_pkg::HDR_QD_HI) begin
          question_total_next = {b, 8'd0};
        end else if (p == dqrr_pkg::HDR_QD_LO) begin
          question_total_next = {question_total[15:8], b};
        end
        if (p >= dqrr_pkg::HDR_LAST) begin
          questions_left_next = question_total;
          parse_phase_next = (question_total != 16'd0) ? dqrr_pkg::PH_LEN
                                                       : dqrr_pkg::PH_DONE;
        end
      end else if (parse_phase != dqrr_pkg::PH_DONE) begin
        if (p >= dqrr_pkg::POS_W'(dqrr_pkg::MAX_PACKET)) begin
          error_code_next = dqrr_pkg::ST_OVERLONG;
        end else begin
          unique case (parse_phase)
            dqrr_pkg::PH_LEN: begin
              if (b == 8'd0) begin
                parse_phase_next      = dqrr_pkg::PH_FIXED;
                fixed_bytes_left_next = dqrr_pkg::FIXED_BYTES;
                echo = 1'b1;
              end else if ((b & dqrr_pkg::PTR_MARK) == dqrr_pkg::PTR_MARK) begin
                parse_phase_next = dqrr_pkg::PH_PTR;
                echo = 1'b1;
              end else if (b > dqrr_pkg::LABEL_MAX) begin
                error_code_next = dqrr_pkg::ST_BADLABEL;
              end else begin
                label_bytes_left_next = b[5:0];
                parse_phase_next      = dqrr_pkg::PH_BODY;
                echo = 1'b1;
              end
            end
            dqrr_pkg::PH_BODY: begin
              label_bytes_left_next = label_bytes_left - 6'd1;
              if (label_bytes_left_next == 6'd0) begin
                parse_phase_next = dqrr_pkg::PH_LEN;
              end
              echo = 1'b1;
            end
            dqrr_pkg::PH_PTR: begin
              parse_phase_next      = dqrr_pkg::PH_FIXED;
              fixed_bytes_left_next = dqrr_pkg::FIXED_BYTES;
              echo = 1'b1;
            end
            default: begin
              // type and class bytes
              fixed_bytes_left_next = fixed_bytes_left - 3'd1;
              if (fixed_bytes_left_next == 3'd0) begin
                questions_left_next = questions_left - 16'd1;
                parse_phase_next = (questions_left_next == 16'd0) ? dqrr_pkg::PH_DONE
                                                                  : dqrr_pkg::PH_LEN;
              end
              echo = 1'b1;
            end
          endcase
        end
      end
    end
    if (echo) begin
      byte_position_next = p_inc;
    end
  end

  // Status as seen after this byte; an unfinished parse is a short or truncated packet.
  always_comb begin
    st = error_code_next;
    if (st == dqrr_pkg::ST_OK && parse_phase_next != dqrr_pkg::PH_DONE) begin
      st = (parse_phase_next == dqrr_pkg::PH_HEADER) ? dqrr_pkg::ST_SHORT
                                                     : dqrr_pkg::ST_TRUNC;
    end
  end

  assign produce = echo || item.is_last;

  always_comb begin
    result.out_byte        = echo ? ob : 8'd0;
    result.has_byte        = echo;
    result.done_res        = item.is_last;
    result.status          = item.is_last ? st : dqrr_pkg::ST_OK;
    result.response_length = (item.is_last && st == dqrr_pkg::ST_OK) ? byte_position_next
                                                                     : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.is_last)) begin
      byte_position    <= '0;
      question_total   <= '0;
      questions_left   <= '0;
      parse_phase      <= dqrr_pkg::PH_HEADER;
      label_bytes_left <= '0;
      fixed_bytes_left <= '0;
      error_code       <= dqrr_pkg::ST_OK;
    end else if (step) begin
      byte_position    <= byte_position_next;
      question_total   <= question_total_next;
      questions_left   <= questions_left_next;
      parse_phase      <= parse_phase_next;
      label_bytes_left <= label_bytes_left_next;
      fixed_bytes_left <= fixed_bytes_left_next;
      error_code       <= error_code_next;
    end
  end

endmodule

### rtl/dns_query_response_rewriter.sv
// Top level: input register, question parser and response output register.
`timescale 1ns / 1ps

// DNS query response rewriter.
// Query bytes enter on query/query_valid/query_ready, one byte per transaction,
// with is_last on the final byte of a packet. Header and question bytes come
// back on resp/resp_valid/resp_ready with the response header flags rewritten;
// bytes after the question section, or after a fault, give no transaction
// unless they carry is_last. The transaction for the last byte has done_res
// set and reports the status and, when ok, the response length.
// Throughput: one byte per cycle unless the receiver stalls. A byte is held in
// an input register, parsed by short logic against the parse state and its
// result lands in the output register.
// When the receiver stalls, the output register holds its result; the input
// register still takes one byte and then query_ready drops until the result
// is taken. Bytes that give no result pass through even while the output
// waits. Reset is synchronous and clears the parse state and the valid flags
// of both registers; the parse state also resets after each packet's last byte.

module dns_query_response_rewriter (
  input  logic             clk,
  input  logic             rst,
  input  logic             query_valid,
  output logic             query_ready,
  input  dqrr_pkg::query_t query,
  output logic             resp_valid,
  input  logic             resp_ready,
  output dqrr_pkg::resp_t  resp
);

  logic             hold_valid;
  dqrr_pkg::query_t hold;
  logic             produce;
  logic             advance;
  dqrr_pkg::resp_t  result;

  dqrr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (hold),
    .produce (produce),
    .result  (result)
  );

  assign advance     = hold_valid && (!produce || !resp_valid || resp_ready);
  assign query_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (query_valid && query_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (query_valid && query_ready) begin
      hold <= query;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (advance && produce) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      resp <= result;
    end
  end

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status != dqrr_pkg::ST_OK |-> resp.done_res)
    else $error("fault status on a transaction that does not end a packet");

  a_result_has_content: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> resp.has_byte || resp.done_res)
    else $error("result transaction carries neither a byte nor an end marker");

  a_dropped_byte_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp.has_byte |-> resp.out_byte == 8'd0)
    else $error("out_byte not zero on an end marker without a byte");

  a_fault_no_length: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status != dqrr_pkg::ST_OK |-> resp.response_length == '0)
    else $error("response length reported for a faulty packet");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("pending result dropped without a handshake");

endmodule
